### src/shs_pkg.sv
package shs_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LAST_FIT_BYTE = 6'd55;
  localparam logic [5:0] LEN_FIRST_BYTE = 6'd56;
  localparam logic [5:0] LAST_BYTE = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD_IDX = 3'd7;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    logic [31:0] f;
    logic [31:0] g;
    logic [31:0] h;
  } work_t;

  typedef struct packed {
    logic       wr_en;
    logic [5:0] wr_addr;
    logic [7:0] wr_byte;
    logic       shift;
    logic       expand;
  } sched_ctl_t;

  localparam work_t INIT_HASH = '{
    a: 32'h6a09e667, b: 32'hbb67ae85, c: 32'h3c6ef372, d: 32'ha54ff53a,
    e: 32'h510e527f, f: 32'h9b05688c, g: 32'h1f83d9ab, h: 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

### src/sha256_stream_hasher.sv
// SHA-256 hasher that takes a message one byte per request.
// Input channel: in_valid/in_ready with req_type and data_byte. A request of
// type append adds data_byte to the message; a request of type finish pads
// the message, runs the last compression and emits the digest.
// Output channel: out_valid/out_ready with digest_word, word_index and
// last_word. A finish request yields eight words, word 0 first, and last_word
// marks word 7. No other request yields output.
// The request that completes a 64-byte block is followed by a compression:
// loading the working words, 64 rounds of the single shared round unit, and a
// fold of the result into the chaining state. A finish request with n bytes
// pending writes the pad byte and fills the rest of the block with padding,
// then runs a compression, and when n exceeds 55 a second padding pass and a
// second compression follow. The eight words then leave at one per cycle while
// out_ready is high.
// in_ready is high only while the block is idle. While the receiver stalls,
// the current word holds and no new request is taken.
// Reset clears the byte count and block count and loads the initial hash values.
module sha256_stream_hasher
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  state_t      state;
  state_t      state_next;
  sched_ctl_t  ctl;
  logic [5:0]  fill;
  logic [54:0] block_count;
  logic [63:0] len_reg;
  logic        finishing;
  logic        len_ok;
  logic [5:0]  rnd;
  logic [2:0]  out_idx;
  work_t       chain;
  work_t       work;
  work_t       round_out;
  logic [31:0] w;
  logic [255:0] chain_bits;
  logic [7:0]  len_byte;
  logic        in_acc;

  assign chain_bits  = chain;
  assign digest_word = chain_bits[8'd255 - {out_idx, 5'b00000} -: 32];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == LAST_WORD_IDX);
  assign len_byte    = len_reg[6'd63 - {fill[2:0], 3'b000} -: 8];

  shs_sched u_sched (
    .clk (clk),
    .ctl (ctl),
    .w   (w)
  );

  shs_round u_round (
    .cur (work),
    .w   (w),
    .k   (ROUND_K[rnd]),
    .nxt (round_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = (state == ST_IDLE);
    out_valid   = (state == ST_EMIT);
    in_acc      = in_valid && in_ready;
    ctl         = '0;
    ctl.wr_addr = fill;
    ctl.expand  = |rnd[5:4];
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          ctl.wr_en   = 1'b1;
          ctl.wr_byte = (req_type == REQ_FINISH) ? PAD_BYTE : data_byte;
          if (fill == LAST_BYTE) begin
            state_next = ST_LOAD;
          end else if (req_type == REQ_FINISH) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_byte = (len_ok && fill >= LEN_FIRST_BYTE) ? len_byte : 8'h00;
        if (fill == LAST_BYTE) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        ctl.shift = 1'b1;
        if (rnd == LAST_ROUND) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (!finishing) begin
          state_next = ST_IDLE;
        end else if (len_ok) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_EMIT: begin
        if (out_ready && out_idx == LAST_WORD_IDX) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      block_count <= '0;
      chain       <= INIT_HASH;
      finishing   <= 1'b0;
      len_ok      <= 1'b0;
      rnd         <= '0;
      out_idx     <= '0;
    end else begin
      if (ctl.wr_en) begin
        fill <= fill + 6'd1;
      end
      if (state == ST_IDLE && in_acc && req_type == REQ_FINISH) begin
        finishing <= 1'b1;
        len_ok    <= (fill <= LAST_FIT_BYTE);
      end
      if (state == ST_ROUND) begin
        rnd <= rnd + 6'd1;
      end
      if (state == ST_FOLD) begin
        chain.a <= chain.a + work.a;
        chain.b <= chain.b + work.b;
        chain.c <= chain.c + work.c;
        chain.d <= chain.d + work.d;
        chain.e <= chain.e + work.e;
        chain.f <= chain.f + work.f;
        chain.g <= chain.g + work.g;
        chain.h <= chain.h + work.h;
        if (!finishing) begin
          block_count <= block_count + 55'd1;
        end else if (!len_ok) begin
          len_ok <= 1'b1;
        end
      end
      if (state == ST_EMIT && out_ready) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == LAST_WORD_IDX) begin
          chain       <= INIT_HASH;
          block_count <= '0;
          finishing   <= 1'b0;
          len_ok      <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_acc && req_type == REQ_FINISH) begin
      len_reg <= {block_count, fill, 3'b000};
    end
    if (state == ST_LOAD) begin
      work <= chain;
    end else if (state == ST_ROUND) begin
      work <= round_out;
    end
  end

endmodule

### src/shs_sched.sv
module shs_sched
  import shs_pkg::*;
(
  input  logic        clk,
  input  sched_ctl_t  ctl,
  output logic [31:0] w
);

  logic [31:0] win [16];
  logic [3:0]  word_sel;
  logic [4:0]  lane_top;

  assign word_sel = ctl.wr_addr[5:2];
  assign lane_top = 5'd31 - {ctl.wr_addr[1:0], 3'b000};

  always_comb begin
    if (ctl.expand) begin
      w = small_sigma1(win[14]) + win[9] + small_sigma0(win[1]) + win[0];
    end else begin
      w = win[0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      win[word_sel][lane_top -: 8] <= ctl.wr_byte;
    end else if (ctl.shift) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= w;
    end
  end

endmodule

### src/shs_round.sv
module shs_round
  import shs_pkg::*;
(
  input  work_t       cur,
  input  logic [31:0] w,
  input  logic [31:0] k,
  output work_t       nxt
);

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  assign ch  = (cur.e & cur.f) ^ (~cur.e & cur.g);
  assign maj = (cur.a & cur.b) ^ (cur.a & cur.c) ^ (cur.b & cur.c);
  assign t1  = cur.h + big_sigma1(cur.e) + ch + k + w;
  assign t2  = big_sigma0(cur.a) + maj;

  always_comb begin
    nxt.a = t1 + t2;
    nxt.b = cur.a;
    nxt.c = cur.b;
    nxt.d = cur.c;
    nxt.e = cur.d + t1;
    nxt.f = cur.e;
    nxt.g = cur.f;
    nxt.h = cur.g;
  end

endmodule

### src/shs_checker.sv
module shs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  // The block takes no request while a digest is being delivered.
  a_no_input_during_output: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted while digest words are pending");

  a_last_marks_seventh: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word does not match word_index");

  a_words_in_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=>
      out_valid && word_index == $past(word_index) + 3'd1)
    else $error("digest words not delivered in sequence");

  a_burst_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_word |=> !out_valid)
    else $error("output continues after the last digest word");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
    else $error("digest word changed while stalled");

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .digest_word (digest_word),
  .word_index  (word_index),
  .last_word   (last_word)
);
